@@ rtl/pdcm_pkg.sv @@
package pdcm_pkg;

    // Tick counter and capture width
    localparam int CNT_W = 16;

    // Duty result width and full-scale value
    localparam int DUTY_W = 7;
    localparam logic [DUTY_W-1:0] DUTY_SCALE = DUTY_W'(100);

    // Product of high time and the duty scale
    localparam int PROD_W = CNT_W + DUTY_W;

    // Quotient bit counter of the divider
    localparam int STEP_W = $clog2(DUTY_W);

    // Measurement queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CNT_W-1:0] count_t;

    // One finished capture set, waiting for the divide
    typedef struct packed {
        count_t high;
        count_t period;
    } pdcm_job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } pdcm_q_stat_t;

endpackage

@@ rtl/pdcm_in_if.sv @@
interface pdcm_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink   (input valid, input line_level, output ready);
endinterface

@@ rtl/pdcm_out_if.sv @@
interface pdcm_out_if
    import pdcm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_percent;
    count_t            high_ticks;
    count_t            period_ticks;
    logic              period_zero;

    modport source (output valid, output duty_percent, output high_ticks,
                    output period_ticks, output period_zero, input ready);
    modport sink   (input valid, input duty_percent, input high_ticks,
                    input period_ticks, input period_zero, output ready);
endinterface

@@ rtl/pdcm_front.sv @@
module pdcm_front
    import pdcm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pdcm_in_if.sink       sample,
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,
    input  pdcm_q_stat_t  q_stat,
    output logic          push,
    output pdcm_job_t     push_job
);

    typedef enum logic [1:0] {
        WAIT_RISE,
        WAIT_FALL1,
        WAIT_RISE2,
        WAIT_FALL2
    } step_t;

    step_t  step_reg, step_next;
    count_t cnt_reg, cnt_next;
    count_t c1_reg, c1_next;
    count_t c2_reg, c2_next;
    logic   prev_reg, prev_next;
    logic   stopped_reg, stopped_next;
    logic   repeat_reg;

    logic accept;
    logic rising;
    logic falling;
    logic clear;

    // Stall the line only when the queue has no room
    assign sample.ready = !q_stat.full;
    assign accept       = sample.valid && sample.ready;
    assign rising       = !prev_reg && sample.line_level;
    assign falling      = prev_reg && !sample.line_level;

    // High time and period from the captures, pushed on the falling edge that closes a measurement
    assign push_job.high   = cnt_reg - c2_reg;
    assign push_job.period = cnt_reg - c1_reg;

    // Classify each item against the edge sequence
    always_comb
    begin
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        c1_next      = c1_reg;
        c2_next      = c2_reg;
        prev_next    = prev_reg;
        stopped_next = stopped_reg;
        push         = 1'b0;
        clear        = 1'b0;

        if (accept && !stopped_reg)
        begin
            prev_next = sample.line_level;
            case (step_reg)
                WAIT_RISE:
                begin
                    if (rising)
                    begin
                        clear     = 1'b1;
                        step_next = WAIT_FALL1;
                    end
                end
                WAIT_FALL1:
                begin
                    if (falling)
                    begin
                        c1_next   = cnt_reg;
                        step_next = WAIT_RISE2;
                    end
                end
                WAIT_RISE2:
                begin
                    if (rising)
                    begin
                        c2_next   = cnt_reg;
                        step_next = WAIT_FALL2;
                    end
                end
                WAIT_FALL2:
                begin
                    if (falling)
                    begin
                        push      = 1'b1;
                        clear     = 1'b1;
                        step_next = WAIT_RISE;
                        if (!repeat_reg)
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    step_next = WAIT_RISE;
                end
            endcase
            cnt_next = clear ? CNT_W'(1) : cnt_reg + CNT_W'(1);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= WAIT_RISE;
            cnt_reg     <= '0;
            c1_reg      <= '0;
            c2_reg      <= '0;
            prev_reg    <= 1'b0;
            stopped_reg <= 1'b0;
            repeat_reg  <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            c1_reg      <= c1_next;
            c2_reg      <= c2_next;
            prev_reg    <= prev_next;
            stopped_reg <= stopped_next;
            if (cfg_wr_en)
            begin
                repeat_reg <= cfg_wr_data;
            end
        end
    end

endmodule

@@ rtl/pdcm_queue.sv @@
module pdcm_queue
    import pdcm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pdcm_job_t     push_job,
    input  logic          pop,
    output pdcm_job_t     pop_job,
    output pdcm_q_stat_t  q_stat
);

    pdcm_job_t mem_reg [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_job      = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        count_next = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/pdcm_back.sv @@
module pdcm_back
    import pdcm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  pdcm_q_stat_t  q_stat,
    input  pdcm_job_t     pop_job,
    output logic          pop,
    pdcm_out_if.source    result
);

    typedef enum logic [2:0] {
        IDLE,
        MUL,
        CHK,
        DIV,
        HOLD
    } state_t;

    state_t            state_reg, state_next;
    count_t            high_reg, high_next;
    count_t            period_reg, period_next;
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] div_reg, div_next;
    logic [DUTY_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              zero_reg, zero_next;

    logic              out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    count_t            out_high_reg, out_high_next;
    count_t            out_period_reg, out_period_next;
    logic              out_zero_reg, out_zero_next;

    logic              slot_free;
    logic              sub_ok;
    logic [PROD_W-1:0] full_scale;

    assign slot_free  = !out_valid_reg || result.ready;
    assign pop        = (state_reg == IDLE) && !q_stat.empty;
    assign sub_ok     = (rem_reg >= div_reg);
    assign full_scale = PROD_W'(period_reg) << DUTY_W;

    assign result.valid        = out_valid_reg;
    assign result.duty_percent = duty_reg;
    assign result.high_ticks   = out_high_reg;
    assign result.period_ticks = out_period_reg;
    assign result.period_zero  = out_zero_reg;

    // Multiply, range check, then one quotient bit a cycle unless the period is zero or saturates
    always_comb
    begin
        state_next      = state_reg;
        high_next       = high_reg;
        period_next     = period_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        zero_next       = zero_reg;
        out_valid_next  = out_valid_reg;
        duty_next       = duty_reg;
        out_high_next   = out_high_reg;
        out_period_next = out_period_reg;
        out_zero_next   = out_zero_reg;

        // Drop the result once taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (!q_stat.empty)
                begin
                    high_next   = pop_job.high;
                    period_next = pop_job.period;
                    state_next  = MUL;
                end
            end
            MUL:
            begin
                rem_next   = PROD_W'(high_reg) * PROD_W'(DUTY_SCALE);
                state_next = CHK;
            end
            CHK:
            begin
                zero_next = 1'b0;
                quo_next  = '0;
                if (period_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = HOLD;
                end
                else if (rem_reg >= full_scale)
                begin
                    quo_next   = DUTY_SCALE;
                    state_next = HOLD;
                end
                else
                begin
                    div_next   = PROD_W'(period_reg) << (DUTY_W - 1);
                    step_next  = STEP_W'(DUTY_W - 1);
                    state_next = DIV;
                end
            end
            DIV:
            begin
                if (sub_ok)
                begin
                    rem_next = rem_reg - div_reg;
                end
                quo_next = {quo_reg[DUTY_W-2:0], sub_ok};
                div_next = div_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = HOLD;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    duty_next       = (quo_reg > DUTY_SCALE) ? DUTY_SCALE : quo_reg;
                    out_high_next   = high_reg;
                    out_period_next = period_reg;
                    out_zero_next   = zero_reg;
                    state_next      = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            out_valid_reg  <= 1'b0;
            high_reg       <= '0;
            period_reg     <= '0;
            rem_reg        <= '0;
            div_reg        <= '0;
            quo_reg        <= '0;
            step_reg       <= '0;
            zero_reg       <= 1'b0;
            duty_reg       <= '0;
            out_high_reg   <= '0;
            out_period_reg <= '0;
            out_zero_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            high_reg       <= high_next;
            period_reg     <= period_next;
            rem_reg        <= rem_next;
            div_reg        <= div_next;
            quo_reg        <= quo_next;
            step_reg       <= step_next;
            zero_reg       <= zero_next;
            duty_reg       <= duty_next;
            out_high_reg   <= out_high_next;
            out_period_reg <= out_period_next;
            out_zero_reg   <= out_zero_next;
        end
    end

endmodule

@@ rtl/pwm_duty_cycle_meter_core.sv @@
// PWM duty-cycle meter. Each sample item is one timer tick of the measured
// line. The tick counter clears on the first rising edge and is captured on
// the following falling, rising and falling edges; at the last one the
// block reports high time, period (both modulo 2^16) and the truncated duty
// percentage, saturated at 100, with period_zero set and duty 0 for a zero
// period. With repeat_mode at 0 the block takes no further measurement after
// the first result until reset; with 1 it re-arms at once. One sample is
// accepted per clock. Each result passes through a two-entry queue to a
// shift-subtract divider that takes it from the queue, multiplies, checks
// the range, forms seven quotient bits and loads the output register; a zero
// or saturated period skips the quotient bits. The divider takes the next
// entry only after loading the last result. A measurement spans at least
// four samples, so the sample input is held off only when the queue fills,
// or when results are not taken from the output.
module pwm_duty_cycle_meter_core
    import pdcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pdcm_in_if.sink     sample,
    pdcm_out_if.source  result,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);

    pdcm_q_stat_t q_stat;
    pdcm_job_t    push_job;
    pdcm_job_t    pop_job;
    logic         push;
    logic         pop;

    pdcm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .push        (push),
        .push_job    (push_job)
    );

    pdcm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    pdcm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .pop_job (pop_job),
        .pop     (pop),
        .result  (result)
    );

endmodule

@@ rtl/pdcm_checker.sv @@
module pdcm_checker
    import pdcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DUTY_W-1:0] duty,
    input  count_t            high,
    input  count_t            period,
    input  logic              zero
);

    // Zero flag tracks the reported period
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (zero == (period == '0)))
        else $error("period_zero does not match period_ticks");

    // Zero period forces zero duty
    a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero) |-> (duty == '0))
        else $error("non-zero duty with zero period");

    // Duty never exceeds full scale nor the true ratio
    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !zero) |->
            ((duty <= DUTY_SCALE) &&
             ((32'(duty) * 32'(period)) <= (32'(high) * 32'(DUTY_SCALE)))))
        else $error("duty above the measured ratio");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(duty) && $stable(high) && $stable(period)))
        else $error("result changed while stalled");

endmodule

bind pwm_duty_cycle_meter_core pdcm_checker u_pdcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .duty      (result.duty_percent),
    .high      (result.high_ticks),
    .period    (result.period_ticks),
    .zero      (result.period_zero)
);

@@ bench/pwm_duty_cycle_meter_core_tb.sv @@
`timescale 1ns / 100ps

module pwm_duty_cycle_meter_core_tb;
    import pdcm_pkg::*;

    localparam int unsigned PCT_FULL       = 100;
    localparam int unsigned GAP_MAX        = 6;
    localparam int unsigned DIV_SLACK      = 16;
    localparam int unsigned SQUEEZE_CYCLES = 3000;
    localparam int unsigned CALM_LEN       = 64;
    localparam int unsigned RUN1_TICKS     = 500;
    localparam int unsigned RUN2_TICKS     = 1000;
    localparam int unsigned IGNORED_TICKS  = 40;
    localparam int unsigned DIR_ROW_CNT    = 13;

    // Edge-capture phases of the meter
    typedef enum logic [2:0] {
        SEEK_RISE   = 3'd0,
        SEEK_FALL_A = 3'd1,
        SEEK_RISE_B = 3'd2,
        SEEK_FALL_B = 3'd3
    } edge_ph_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        count_t            high;
        count_t            period;
        logic              zero;
    } meas_t;

    // One stretch of constant line level; a typed measurement belongs to its last tick
    typedef struct packed {
        logic        lvl;
        logic [31:0] len;
        logic        typed;
        meas_t       res;
    } row_t;

    localparam meas_t NO_MEAS = '0;

    localparam row_t DIR_ROWS [DIR_ROW_CNT] = '{
        // line high on the very first tick, then the shortest possible pulse train
        '{1'b1, 32'd1,     1'b0, NO_MEAS},
        '{1'b0, 32'd1,     1'b0, NO_MEAS},
        '{1'b1, 32'd1,     1'b0, NO_MEAS},
        '{1'b0, 32'd1,     1'b1, '{7'd50, 16'd1, 16'd2, 1'b0}},
        // idle low, then a wide pulse
        '{1'b0, 32'd3,     1'b0, NO_MEAS},
        '{1'b1, 32'd1,     1'b0, NO_MEAS},
        '{1'b0, 32'd1,     1'b0, NO_MEAS},
        '{1'b1, 32'd9,     1'b0, NO_MEAS},
        '{1'b0, 32'd1,     1'b1, '{7'd90, 16'd9, 16'd10, 1'b0}},
        // narrow pulse after a long low
        '{1'b1, 32'd1,     1'b0, NO_MEAS},
        '{1'b0, 32'd40,    1'b0, NO_MEAS},
        '{1'b1, 32'd1,     1'b0, NO_MEAS},
        '{1'b0, 32'd1,     1'b0, NO_MEAS}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    pdcm_in_if  smp ();
    pdcm_out_if res ();

    pwm_duty_cycle_meter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (smp),
        .result      (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Meter state as seen by the predictor
    count_t      tick_cnt = '0;
    logic        last_lvl = 1'b0;
    edge_ph_t    edge_ph  = SEEK_RISE;
    count_t      fall_cap = '0;
    count_t      rise_cap = '0;
    logic        halted   = 1'b0;
    logic        rep_mode = 1'b0;

    meas_t       meas_q [$];
    int unsigned err_cnt    = 0;
    int unsigned live_ticks = 0;
    bit          squeeze_req = 1'b0;
    bit          squeezed    = 1'b0;
    bit          rx_calm     = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the predicted meter by one tick; return 1 when a measurement completes
    function automatic bit measure_tick(input logic lvl, output meas_t m);
        logic            rise;
        logic            fall;
        logic            restart;
        bit              done;
        count_t          now;
        count_t          hi;
        count_t          per;
        longint unsigned ratio;
        rise    = !last_lvl && lvl;
        fall    = last_lvl && !lvl;
        now     = tick_cnt;
        restart = 1'b0;
        done    = 1'b0;
        m       = '0;
        if (!halted)
        begin
            last_lvl = lvl;
            case (edge_ph)
                SEEK_FALL_A:
                begin
                    if (fall)
                    begin
                        fall_cap = now;
                        edge_ph  = SEEK_RISE_B;
                    end
                end
                SEEK_RISE_B:
                begin
                    if (rise)
                    begin
                        rise_cap = now;
                        edge_ph  = SEEK_FALL_B;
                    end
                end
                SEEK_FALL_B:
                begin
                    if (fall)
                    begin
                        hi       = now - rise_cap;
                        per      = now - fall_cap;
                        m.high   = hi;
                        m.period = per;
                        if (per == '0)
                        begin
                            m.zero = 1'b1;
                        end
                        else
                        begin
                            ratio = (64'(hi) * PCT_FULL) / 64'(per);
                            if (ratio > PCT_FULL)
                            begin
                                ratio = PCT_FULL;
                            end
                            m.duty = DUTY_W'(ratio);
                        end
                        done    = 1'b1;
                        restart = 1'b1;
                        edge_ph = SEEK_RISE;
                        if (!rep_mode)
                        begin
                            halted = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (rise)
                    begin
                        restart = 1'b1;
                        edge_ph = SEEK_FALL_A;
                    end
                end
            endcase
            tick_cnt = restart ? count_t'(1) : now + count_t'(1);
        end
        return done;
    endfunction

    // Offer one sample item after a random gap (none when calm) and hold it until taken
    task automatic send_level(input logic lvl, input bit calm);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.valid      <= 1'b1;
        smp.line_level <= lvl;
        @(posedge clk);
        while (!smp.ready) @(posedge clk);
    endtask

    task automatic drive_tick(input logic lvl, input bit calm);
        meas_t m;
        if (!halted)
        begin
            live_ticks++;
        end
        send_level(lvl, calm);
        if (measure_tick(lvl, m))
        begin
            meas_q.push_back(m);
        end
    endtask

    function automatic int unsigned pulse_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            return $urandom_range(1, 8);
        end
        else if (pick < 95)
        begin
            return $urandom_range(9, 60);
        end
        return $urandom_range(61, 300);
    endfunction

    // Mostly clean pulses of random width, some glitchy noise
    task automatic send_wave();
        int unsigned hi_len;
        int unsigned lo_len;
        bit          calm;
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 6)) drive_tick(1'($urandom_range(0, 1)), calm);
        end
        else
        begin
            hi_len = pulse_len();
            lo_len = pulse_len();
            repeat (hi_len) drive_tick(1'b1, calm);
            repeat (lo_len) drive_tick(1'b0, calm);
        end
    endtask

    // Drop valid, wait for every pending measurement and let the divider go quiet
    task automatic settle();
        smp.valid <= 1'b0;
        while (meas_q.size() != 0) @(posedge clk);
        repeat (DIV_SLACK) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        rep_mode     = mode;
    endtask

    // Stimulus
    initial
    begin : stimulus
        row_t  row;
        meas_t m;
        bit    got;
        rst_n          <= 1'b0;
        smp.valid      <= 1'b0;
        smp.line_level <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b1);

        // Walk the directed table
        for (int i = 0; i < DIR_ROW_CNT; i++)
        begin
            row = DIR_ROWS[i];
            for (int unsigned k = 0; k < row.len; k++)
            begin
                send_level(row.lvl, row.len > CALM_LEN);
                got = measure_tick(row.lvl, m);
                if (row.typed && k == row.len - 1)
                begin
                    meas_q.push_back(row.res);
                end
                else if (got)
                begin
                    meas_q.push_back(m);
                end
            end
        end
        settle();

        // Continuous random traffic, with one long hold-off on the result side
        squeeze_req = 1'b1;
        live_ticks  = 0;
        while (live_ticks < RUN1_TICKS) send_wave();
        settle();

        // Switch to one-shot mid-measurement, then back before the closing edge
        write_mode(1'b0);
        while (edge_ph != SEEK_FALL_B) drive_tick(!last_lvl, 1'b0);
        settle();
        write_mode(1'b1);
        while (live_ticks < RUN2_TICKS) send_wave();
        settle();

        // One-shot: the block stops after one measurement and ignores the rest
        write_mode(1'b0);
        while (!halted) send_wave();
        repeat (IGNORED_TICKS) drive_tick(1'($urandom_range(0, 1)), 1'b0);
        settle();
        write_mode(1'b1);
        repeat (IGNORED_TICKS / 2) drive_tick(1'($urandom_range(0, 1)), 1'b0);
        settle();

        if (err_cnt == 0)
        begin
            $display("pwm_duty_cycle_meter_core test passed");
        end
        else
        begin
            $display("pwm_duty_cycle_meter_core test failed");
        end
        $finish;
    end

    // Result sink: check each item against the oldest pending measurement
    initial
    begin : result_sink
        int unsigned stall;
        meas_t       want;
        res.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        res.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (res.valid && res.ready)
            begin
                if (meas_q.size() == 0)
                begin
                    $error("unexpected result: duty_percent %0d high_ticks %0d period_ticks %0d",
                           res.duty_percent, res.high_ticks, res.period_ticks);
                    err_cnt++;
                end
                else
                begin
                    want = meas_q.pop_front();
                    if (res.duty_percent !== want.duty)
                    begin
                        $error("duty_percent: expected %0d, got %0d", want.duty, res.duty_percent);
                        err_cnt++;
                    end
                    if (res.high_ticks !== want.high)
                    begin
                        $error("high_ticks: expected %0d, got %0d", want.high, res.high_ticks);
                        err_cnt++;
                    end
                    if (res.period_ticks !== want.period)
                    begin
                        $error("period_ticks: expected %0d, got %0d",
                               want.period, res.period_ticks);
                        err_cnt++;
                    end
                    if (res.period_zero !== want.zero)
                    begin
                        $error("period_zero: expected %0d, got %0d", want.zero, res.period_zero);
                        err_cnt++;
                    end
                end

                // Hold off once for long enough to back the block up to its input
                if (squeeze_req && !squeezed)
                begin
                    stall    = SQUEEZE_CYCLES;
                    squeezed = 1'b1;
                end
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        rx_calm = !rx_calm;
                    end
                    stall = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
                end
                if (stall != 0)
                begin
                    res.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    res.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        #10_000_000;
        $display("pwm_duty_cycle_meter_core test failed");
        $finish;
    end

endmodule
